[rtl/text_console_cursor_writer_assert.svh]
// Assertion macros for the text console cursor writer.
// Used by the top level; relies on clk and rst being in scope.
`ifndef TEXT_CONSOLE_CURSOR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_WRITER_ASSERT_SVH

// same-cycle implication
`define TCCW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tccw: assertion failed");

// next-cycle implication
`define TCCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tccw: assertion failed");

`endif

[rtl/tccw_pkg.sv]
// Package for the text console cursor writer: screen constants, codes,
// and controller/datapath command and status types. No dependencies.
`default_nettype none

package tccw_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int TAB_STOP       = 8;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int BYTE_W = 8;
  localparam int TAB_W  = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;

  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [BYTE_W-1:0] CH_TAB       = 8'd9;
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [BYTE_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [BYTE_W-1:0] ATTR_TEXT    = 8'd7;
  localparam logic [BYTE_W-1:0] ATTR_CLEAR   = 8'd0;
  localparam logic [BYTE_W-1:0] GLYPH_CLEAR  = 8'd0;

  typedef enum logic [2:0] {
    CLS_PRINT,
    CLS_NEWLINE,
    CLS_RETURN,
    CLS_BACKSPACE,
    CLS_TAB
  } char_cls_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_BACKSPACE,
    OP_RETURN,
    OP_NEWLINE,
    OP_CLEAR_ROW,
    OP_PUT_CHAR,
    OP_PUT_SPACE
  } dp_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEND,
    ST_SEND_NL,
    ST_CLEAR_ROW,
    ST_SEND_TAB
  } ctrl_state_t;

  typedef struct packed {
    logic   capture;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    char_cls_t cls;
    logic      phase_zero;
    logic      span_last;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/tccw_ctrl.sv]
// Controller FSM for the text console cursor writer.
// Depends on tccw_pkg for state, command and status types.
`default_nettype none

module tccw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tccw_pkg::dp_status_t status,
  output tccw_pkg::dp_cmd_t    cmd
);

  tccw_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tccw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tccw_pkg::ST_IDLE: begin
        if (in_valid) state_next = tccw_pkg::ST_DECODE;
      end
      tccw_pkg::ST_DECODE: begin
        case (status.cls)
          tccw_pkg::CLS_NEWLINE:   state_next = tccw_pkg::ST_SEND_NL;
          tccw_pkg::CLS_RETURN:    state_next = tccw_pkg::ST_SEND;
          tccw_pkg::CLS_BACKSPACE: state_next = tccw_pkg::ST_IDLE;
          tccw_pkg::CLS_TAB: begin
            state_next = status.phase_zero ? tccw_pkg::ST_IDLE : tccw_pkg::ST_SEND_TAB;
          end
          default:                 state_next = tccw_pkg::ST_SEND;
        endcase
      end
      tccw_pkg::ST_SEND: begin
        if (out_ready) state_next = tccw_pkg::ST_IDLE;
      end
      tccw_pkg::ST_SEND_NL: begin
        if (out_ready) state_next = tccw_pkg::ST_CLEAR_ROW;
      end
      tccw_pkg::ST_CLEAR_ROW: begin
        state_next = tccw_pkg::ST_SEND;
      end
      tccw_pkg::ST_SEND_TAB: begin
        if (out_ready) begin
          state_next = status.span_last ? tccw_pkg::ST_IDLE : tccw_pkg::ST_DECODE;
        end
      end
      default: state_next = tccw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == tccw_pkg::ST_IDLE);
    out_valid   = (state == tccw_pkg::ST_SEND) || (state == tccw_pkg::ST_SEND_NL) ||
                  (state == tccw_pkg::ST_SEND_TAB);
    cmd.capture = (state == tccw_pkg::ST_IDLE);
    cmd.op      = tccw_pkg::OP_NONE;
    case (state)
      tccw_pkg::ST_DECODE: begin
        case (status.cls)
          tccw_pkg::CLS_NEWLINE:   cmd.op = tccw_pkg::OP_NEWLINE;
          tccw_pkg::CLS_RETURN:    cmd.op = tccw_pkg::OP_RETURN;
          tccw_pkg::CLS_BACKSPACE: cmd.op = tccw_pkg::OP_BACKSPACE;
          tccw_pkg::CLS_TAB: begin
            cmd.op = status.phase_zero ? tccw_pkg::OP_NONE : tccw_pkg::OP_PUT_SPACE;
          end
          default:                 cmd.op = tccw_pkg::OP_PUT_CHAR;
        endcase
      end
      tccw_pkg::ST_CLEAR_ROW: cmd.op = tccw_pkg::OP_CLEAR_ROW;
      default:                cmd.op = tccw_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/tccw_dp.sv]
// Datapath for the text console cursor writer: cursor, tab phase,
// captured character and output span register. Depends on tccw_pkg.
`default_nettype none

module tccw_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  tccw_pkg::dp_cmd_t                   cmd,
  output tccw_pkg::dp_status_t                status,
  input  logic [tccw_pkg::BYTE_W-1:0]         char_code,
  output logic [tccw_pkg::ROW_W-1:0]          row,
  output logic [tccw_pkg::COL_W-1:0]          start_col,
  output logic [tccw_pkg::COL_W-1:0]          cell_count,
  output logic [tccw_pkg::BYTE_W-1:0]         glyph,
  output logic [tccw_pkg::BYTE_W-1:0]         attribute,
  output logic                                last
);

  localparam int COL_W = tccw_pkg::COL_W;
  localparam int ROW_W = tccw_pkg::ROW_W;
  localparam int TAB_W = tccw_pkg::TAB_W;

  logic [COL_W-1:0]          cursor_col;
  logic [ROW_W-1:0]          cursor_row;
  logic [TAB_W-1:0]          phase;
  logic [tccw_pkg::BYTE_W-1:0] ch;

  logic [COL_W:0]   col_inc;
  logic [TAB_W:0]   phase_inc;
  logic [ROW_W-1:0] row_next;
  logic [COL_W:0]   rest_count;
  logic             wrap;
  logic             tab_last;

  assign col_inc    = {1'b0, cursor_col} + (COL_W+1)'(1);
  assign phase_inc  = {1'b0, phase} + (TAB_W+1)'(1);
  assign wrap       = (col_inc == (COL_W+1)'(tccw_pkg::SCREEN_COLUMNS));
  assign tab_last   = wrap || (phase_inc == (TAB_W+1)'(tccw_pkg::TAB_STOP));
  assign row_next   = (cursor_row == ROW_W'(tccw_pkg::SCREEN_ROWS - 1)) ? '0
                                                                      : cursor_row + 1'b1;
  assign rest_count = (COL_W+1)'(tccw_pkg::SCREEN_COLUMNS) - {1'b0, cursor_col};

  always_comb begin
    case (ch)
      tccw_pkg::CH_NEWLINE:   status.cls = tccw_pkg::CLS_NEWLINE;
      tccw_pkg::CH_RETURN:    status.cls = tccw_pkg::CLS_RETURN;
      tccw_pkg::CH_BACKSPACE: status.cls = tccw_pkg::CLS_BACKSPACE;
      tccw_pkg::CH_TAB:       status.cls = tccw_pkg::CLS_TAB;
      default:                status.cls = tccw_pkg::CLS_PRINT;
    endcase
    status.phase_zero = (phase == '0);
    status.span_last  = last;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) ch <= char_code;
  end

  // cursor and tab phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      phase      <= '0;
    end else begin
      case (cmd.op)
        tccw_pkg::OP_BACKSPACE: begin
          if (cursor_col != '0) begin
            cursor_col <= cursor_col - 1'b1;
            phase      <= (phase == '0) ? TAB_W'(tccw_pkg::TAB_STOP - 1) : phase - 1'b1;
          end
        end
        tccw_pkg::OP_RETURN: begin
          cursor_col <= '0;
          phase      <= '0;
        end
        tccw_pkg::OP_NEWLINE: begin
          cursor_col <= '0;
          phase      <= '0;
          cursor_row <= row_next;
        end
        tccw_pkg::OP_PUT_CHAR, tccw_pkg::OP_PUT_SPACE: begin
          if (wrap) begin
            cursor_col <= '0;
            phase      <= '0;
            cursor_row <= row_next;
          end else begin
            cursor_col <= col_inc[COL_W-1:0];
            phase      <= (phase_inc == (TAB_W+1)'(tccw_pkg::TAB_STOP)) ? '0
                                                                       : phase_inc[TAB_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // output span register
  always_ff @(posedge clk) begin
    case (cmd.op)
      tccw_pkg::OP_RETURN, tccw_pkg::OP_NEWLINE: begin
        row        <= cursor_row;
        start_col  <= cursor_col;
        cell_count <= rest_count[COL_W-1:0];
        glyph      <= tccw_pkg::GLYPH_CLEAR;
        attribute  <= tccw_pkg::ATTR_CLEAR;
        last       <= (cmd.op == tccw_pkg::OP_RETURN);
      end
      tccw_pkg::OP_CLEAR_ROW: begin
        row        <= cursor_row;
        start_col  <= '0;
        cell_count <= COL_W'(tccw_pkg::SCREEN_COLUMNS);
        glyph      <= tccw_pkg::GLYPH_CLEAR;
        attribute  <= tccw_pkg::ATTR_CLEAR;
        last       <= 1'b1;
      end
      tccw_pkg::OP_PUT_CHAR: begin
        row        <= cursor_row;
        start_col  <= cursor_col;
        cell_count <= COL_W'(1);
        glyph      <= ch;
        attribute  <= tccw_pkg::ATTR_TEXT;
        last       <= 1'b1;
      end
      tccw_pkg::OP_PUT_SPACE: begin
        row        <= cursor_row;
        start_col  <= cursor_col;
        cell_count <= COL_W'(1);
        glyph      <= tccw_pkg::CH_SPACE;
        attribute  <= tccw_pkg::ATTR_TEXT;
        last       <= tab_last;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/text_console_cursor_writer.sv]
// Top level of the text console cursor writer: controller plus datapath.
// Depends on tccw_pkg, tccw_ctrl, tccw_dp and the assertion macro header.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------------------
//   input    | in_valid, in_ready  | char_code
//   output   | out_valid,out_ready | row, start_col, cell_count, glyph, attribute, last
//
// Per character: printable and return pass idle, decode and send; newline passes idle,
// decode, send, clear row and send; backspace passes idle and decode with no output; tab
// repeats decode and send once per space cell (no output when already on a stop). The
// controller issues each datapath op through a single output span register.
// Synchronous reset puts the cursor at row 0, column 0.
// Output stalls hold the span register and the controller; input waits meanwhile.
`default_nettype none
`include "text_console_cursor_writer_assert.svh"

module text_console_cursor_writer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tccw_pkg::BYTE_W-1:0] char_code,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tccw_pkg::ROW_W-1:0]  row,
  output logic [tccw_pkg::COL_W-1:0]  start_col,
  output logic [tccw_pkg::COL_W-1:0]  cell_count,
  output logic [tccw_pkg::BYTE_W-1:0] glyph,
  output logic [tccw_pkg::BYTE_W-1:0] attribute,
  output logic                        last
);

  tccw_pkg::dp_cmd_t    cmd;
  tccw_pkg::dp_status_t status;

  logic [tccw_pkg::COL_W:0] span_end;
  logic                     span_fits;

  tccw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tccw_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .char_code  (char_code),
    .row        (row),
    .start_col  (start_col),
    .cell_count (cell_count),
    .glyph      (glyph),
    .attribute  (attribute),
    .last       (last)
  );

  assign span_end  = {1'b0, start_col} + {1'b0, cell_count};
  assign span_fits = (cell_count != '0) &&
                     (span_end <= (tccw_pkg::COL_W+1)'(tccw_pkg::SCREEN_COLUMNS));

  `TCCW_ASSERT_NOW(a_no_accept_while_sending, in_valid && in_ready, !out_valid)
  `TCCW_ASSERT_NEXT(a_last_frees_input, out_valid && out_ready && last, in_ready)
  `TCCW_ASSERT_NEXT(a_more_after_not_last, out_valid && out_ready && !last, !in_ready)
  `TCCW_ASSERT_NOW(a_span_in_row, out_valid, span_fits)

endmodule

`default_nettype wire

[verif/text_console_cursor_writer_tb.sv]
// Testbench for text_console_cursor_writer: drives characters through the
// valid/ready input, predicts each cell-span write and checks every transfer.
// Depends on tccw_pkg and the RTL of the block only.
`default_nettype none

module text_console_cursor_writer_tb;

  localparam int ROW_W  = tccw_pkg::ROW_W;
  localparam int COL_W  = tccw_pkg::COL_W;
  localparam int BYTE_W = tccw_pkg::BYTE_W;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [ROW_W-1:0]  span_row;
    logic [COL_W-1:0]  span_col;
    logic [COL_W-1:0]  span_cells;
    logic [BYTE_W-1:0] span_glyph;
    logic [BYTE_W-1:0] span_attr;
    logic              span_last;
  } span_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] char_code = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  start_col;
  logic [COL_W-1:0]  cell_count;
  logic [BYTE_W-1:0] glyph;
  logic [BYTE_W-1:0] attribute;
  logic              last;

  span_t       expected_spans[$];
  logic [COL_W-1:0] cur_col = '0;
  logic [ROW_W-1:0] cur_row = '0;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;

  text_console_cursor_writer i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row        (row),
    .start_col  (start_col),
    .cell_count (cell_count),
    .glyph      (glyph),
    .attribute  (attribute),
    .last       (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("text_console_cursor_writer_tb NOT OK");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    span_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{row, start_col, cell_count, glyph, attribute, last};
      if (expected_spans.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected row=%0d col=%0d cells=%0d glyph=%0d attr=%0d last=%0d",
                 $time, row, start_col, cell_count, glyph, attribute, last);
      end else begin
        want = expected_spans.pop_front();
        if (got != want) begin
          mismatch_count++;
          $display("%0t: mismatch exp row=%0d col=%0d cells=%0d glyph=%0d attr=%0d last=%0d",
                   $time, want.span_row, want.span_col, want.span_cells, want.span_glyph,
                   want.span_attr, want.span_last);
          $display("%0t:          got row=%0d col=%0d cells=%0d glyph=%0d attr=%0d last=%0d",
                   $time, row, start_col, cell_count, glyph, attribute, last);
        end
      end
    end
  end

  // cursor step; returns 1 when it wrapped to the next row
  function automatic logic step_cursor();
    if (cur_col == COL_W'(tccw_pkg::SCREEN_COLUMNS - 1)) begin
      cur_col = '0;
      cur_row = (cur_row == ROW_W'(tccw_pkg::SCREEN_ROWS - 1)) ? '0 : cur_row + 1'b1;
      return 1'b1;
    end
    cur_col = cur_col + 1'b1;
    return 1'b0;
  endfunction

  task automatic predict_char_spans(input logic [BYTE_W-1:0] c);
    span_t spans[8];
    int n;
    int stop_col;
    n = 0;
    case (c)
      tccw_pkg::CH_NEWLINE: begin
        spans[n++] = '{cur_row, cur_col, COL_W'(tccw_pkg::SCREEN_COLUMNS) - cur_col,
                       tccw_pkg::GLYPH_CLEAR, tccw_pkg::ATTR_CLEAR, 1'b0};
        cur_col = '0;
        cur_row = (cur_row == ROW_W'(tccw_pkg::SCREEN_ROWS - 1)) ? '0 : cur_row + 1'b1;
        spans[n++] = '{cur_row, '0, COL_W'(tccw_pkg::SCREEN_COLUMNS),
                       tccw_pkg::GLYPH_CLEAR, tccw_pkg::ATTR_CLEAR, 1'b0};
      end
      tccw_pkg::CH_RETURN: begin
        spans[n++] = '{cur_row, cur_col, COL_W'(tccw_pkg::SCREEN_COLUMNS) - cur_col,
                       tccw_pkg::GLYPH_CLEAR, tccw_pkg::ATTR_CLEAR, 1'b0};
        cur_col = '0;
      end
      tccw_pkg::CH_BACKSPACE: begin
        if (cur_col != 0) cur_col = cur_col - 1'b1;
      end
      tccw_pkg::CH_TAB: begin
        stop_col = ((int'(cur_col) + tccw_pkg::TAB_STOP - 1) / tccw_pkg::TAB_STOP)
                   * tccw_pkg::TAB_STOP;
        while (int'(cur_col) < stop_col && n < 8) begin
          spans[n++] = '{cur_row, cur_col, COL_W'(1), tccw_pkg::CH_SPACE,
                         tccw_pkg::ATTR_TEXT, 1'b0};
          if (step_cursor()) break;
        end
      end
      default: begin
        spans[n++] = '{cur_row, cur_col, COL_W'(1), c, tccw_pkg::ATTR_TEXT, 1'b0};
        void'(step_cursor());
      end
    endcase
    for (int i = 0; i < n; i++) begin
      spans[i].span_last = (i == n - 1);
      expected_spans.push_back(spans[i]);
    end
  endtask

  task automatic send_char(input logic [BYTE_W-1:0] c);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (!in_ready);
    predict_char_spans(c);
  endtask

  function automatic logic [BYTE_W-1:0] random_printable();
    logic [BYTE_W-1:0] c;
    do c = BYTE_W'($urandom_range(255));
    while (c == tccw_pkg::CH_NEWLINE || c == tccw_pkg::CH_RETURN ||
           c == tccw_pkg::CH_BACKSPACE || c == tccw_pkg::CH_TAB);
    return c;
  endfunction

  // print off a tab stop, then tab to the next stop while it stays within target
  task automatic move_to_col(input int target);
    while (int'(cur_col) != target) begin
      if ((int'(cur_col) % tccw_pkg::TAB_STOP) != 0 &&
          ((int'(cur_col) / tccw_pkg::TAB_STOP) + 1) * tccw_pkg::TAB_STOP <= target)
        send_char(tccw_pkg::CH_TAB);
      else
        send_char(random_printable());
    end
  endtask

  task automatic test_directed();
    logic [BYTE_W-1:0] codes[$];
    codes = {8'd65, 8'd0, 8'd255, 8'd127, 8'd128, tccw_pkg::CH_SPACE, tccw_pkg::CH_TAB,
             tccw_pkg::CH_TAB, tccw_pkg::CH_BACKSPACE, tccw_pkg::CH_TAB, tccw_pkg::CH_RETURN,
             tccw_pkg::CH_BACKSPACE, tccw_pkg::CH_TAB, tccw_pkg::CH_NEWLINE,
             8'd1, 8'd7, 8'hAA, 8'h55, tccw_pkg::CH_NEWLINE, tccw_pkg::CH_RETURN, 8'd66,
             tccw_pkg::CH_BACKSPACE, tccw_pkg::CH_BACKSPACE, tccw_pkg::CH_NEWLINE};
    foreach (codes[i]) send_char(codes[i]);
  endtask

  // bottom row, printable wrap at the bottom right corner, tab across the right edge
  task automatic test_screen_edges();
    while (cur_row != ROW_W'(tccw_pkg::SCREEN_ROWS - 1)) send_char(tccw_pkg::CH_NEWLINE);
    move_to_col(tccw_pkg::SCREEN_COLUMNS - 1);
    send_char(random_printable());
    move_to_col(tccw_pkg::SCREEN_COLUMNS - 7);
    send_char(tccw_pkg::CH_TAB);
  endtask

  task automatic test_random_text(input int items, input int idle, input int stall);
    int sent;
    int line_len;
    int pick;
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        send_char(BYTE_W'($urandom_range(255)));
        sent++;
      end else begin
        line_len = ($urandom_range(3) == 0) ? $urandom_range(60, 90) : $urandom_range(0, 15);
        for (int i = 0; i < line_len; i++) begin
          pick = $urandom_range(99);
          if (pick < 8) send_char(tccw_pkg::CH_TAB);
          else if (pick < 12) send_char(tccw_pkg::CH_BACKSPACE);
          else send_char(random_printable());
        end
        sent += line_len;
        pick = $urandom_range(9);
        if (pick < 5) send_char(tccw_pkg::CH_NEWLINE);
        else if (pick < 8) send_char(tccw_pkg::CH_RETURN);
        sent++;
      end
    end
  endtask

  task automatic test_output_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    send_char(8'd88);
    hold_left = 300;
    for (int i = 0; i < 30; i++) begin
      case ($urandom_range(2))
        0: send_char(tccw_pkg::CH_NEWLINE);
        1: send_char(tccw_pkg::CH_TAB);
        default: send_char(random_printable());
      endcase
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_screen_edges();
    test_random_text(20, 0, 0);
    test_random_text(20, 67, 0);
    test_random_text(20, 0, 67);
    test_random_text(20, 20, 20);
    test_output_backpressure();
    @(negedge clk);
    in_valid <= 1'b0;
    stall_pct = 0;
    wait (expected_spans.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_spans.size() == 0)
      $display("text_console_cursor_writer_tb OK");
    else
      $display("text_console_cursor_writer_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
